/* rtl/core/mbpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpm_pkg: shared types and constants
// Constants, register indexes and control structs for the poll master.
// ----------------------------------------------------------------------------
package mbpm_pkg;

	localparam int NumBoards  = 4;
	localparam int ReplyBytes = 32;
	localparam int MinReply   = 13;

	localparam logic [15:0] CrcInit  = 16'hFFFF;
	localparam logic [15:0] CrcPoly  = 16'hA001;
	localparam logic [7:0]  FuncRead = 8'h04;
	localparam logic [7:0]  FuncExc  = 8'h84;

	localparam logic [15:0] PeriodReset  = 16'd1000;
	localparam logic [15:0] TimeoutReset = 16'd300;
	localparam logic [7:0]  LimitReset   = 8'd3;
	localparam logic [7:0]  AddrReset    = 8'd1;

	localparam logic [1:0] RegPeriod  = 2'd0;
	localparam logic [1:0] RegTimeout = 2'd1;
	localparam logic [1:0] RegLimit   = 2'd2;
	localparam logic [1:0] RegAddr    = 2'd3;

	localparam logic [2:0] ErrOk     = 3'd0;
	localparam logic [2:0] ErrNoRep  = 3'd1;
	localparam logic [2:0] ErrExc    = 3'd2;
	localparam logic [2:0] ErrHeader = 3'd3;
	localparam logic [2:0] ErrCrc    = 3'd4;
	localparam logic [2:0] ErrCount  = 3'd5;

	localparam logic KindTx     = 1'b0;
	localparam logic KindReport = 1'b1;

	typedef struct packed {
		logic [1:0]  state;
		logic        valve;
		logic [15:0] flow;
		logic [15:0] dispensed;
		logic [15:0] target;
		logic [7:0]  fails;
	} board_rec_t;

	// controller -> datapath
	typedef struct packed {
		logic crc_clear;   // load CRC init
		logic crc_byte;    // fold one byte into CRC
		logic crc_req;     // fold byte from request sequence (else buffer)
		logic rd_start;    // buffer read pointer reset
		logic buf_clear;   // reply length reset
		logic judge;       // compute verdict and update record
		logic out_tx;      // load tx byte into output
		logic out_last;
		logic [2:0] req_idx;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       rd_done;  // walked len-2 bytes
		logic       needs_crc;
	} dp_stat_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/mbpm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpm_in_if / mbpm_out_if: stream channels
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mbpm_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;
	modport source (output valid, func, rx_byte, input ready);
	modport sink (input valid, func, rx_byte, output ready);
endinterface

interface mbpm_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic [1:0]  board_index;
	logic [1:0]  board_state;
	logic        valve_open;
	logic [15:0] flow_count;
	logic [15:0] dispensed_tenths;
	logic [15:0] target_tenths;
	logic [7:0]  fail_count;
	logic [2:0]  error_code;
	logic        last;
	modport source (output valid, kind, tx_byte, board_index, board_state, valve_open,
		flow_count, dispensed_tenths, target_tenths, fail_count, error_code, last,
		input ready);
	modport sink (input valid, kind, tx_byte, board_index, board_state, valve_open,
		flow_count, dispensed_tenths, target_tenths, fail_count, error_code, last,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/mbpm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpm_datapath: reply buffer, CRC unit, board table and output register
// Stores reply bytes, walks the CRC byte by byte, judges replies.
// ----------------------------------------------------------------------------
module mbpm_datapath #(
	parameter int NUM_BOARDS  = mbpm_pkg::NumBoards,
	parameter int REPLY_BYTES = mbpm_pkg::ReplyBytes,
	localparam int BW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1,
	localparam int AW = $clog2(REPLY_BYTES),
	localparam int LW = $clog2(REPLY_BYTES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mbpm_pkg::dp_cmd_t  cmd,
	output mbpm_pkg::dp_stat_t      stat,
	input  wire logic               rx_wr,
	input  wire logic [7:0]         rx_data,
	input  wire logic [BW-1:0]      cursor,
	input  wire logic [7:0]         first_address,
	input  wire logic [7:0]         fail_limit,
	input  wire logic               out_take,
	output logic                    out_valid,
	output logic                    o_kind,
	output logic [7:0]              o_tx,
	output logic [1:0]              o_board,
	output mbpm_pkg::board_rec_t    o_rec,
	output logic [2:0]              o_err,
	output logic                    o_last
);
	logic [7:0] mem_q [REPLY_BYTES];
	logic [LW-1:0] len_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic [7:0] hdr_q [3:10];
	logic [LW-1:0] rd_q;
	logic [7:0] rdat_q;
	logic       rdat_v_q;
	logic [15:0] crc_q;
	logic [7:0] crc_lo_q, crc_hi_q;
	mbpm_pkg::board_rec_t tbl_q [NUM_BOARDS];
	logic [7:0] addr;
	logic [7:0] req_byte;
	logic [15:0] req_crc;
	logic [LW-1:0] len_m2;

	assign addr = first_address + 8'(cursor);
	assign len_m2 = len_q - LW'(2);
	assign stat.rd_done = (rd_q >= len_m2) && !rdat_v_q;
	assign stat.needs_crc = (len_q >= LW'(mbpm_pkg::MinReply)) && b0_q == addr
		&& b1_q == mbpm_pkg::FuncRead;

	// request bytes come from the crc register for the tail
	always_comb begin
		req_crc = crc_q;
		unique case (cmd.req_idx)
			3'd0: req_byte = addr;
			3'd1: req_byte = mbpm_pkg::FuncRead;
			3'd5: req_byte = 8'h04;
			3'd6: req_byte = req_crc[7:0];
			3'd7: req_byte = req_crc[15:8];
			default: req_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rx_wr && len_q < LW'(REPLY_BYTES)) begin
			mem_q[len_q[AW-1:0]] <= rx_data;
			unique case (len_q)
				LW'(0): b0_q <= rx_data;
				LW'(1): b1_q <= rx_data;
				LW'(2): b2_q <= rx_data;
				default: ;
			endcase
			if (len_q >= LW'(3) && len_q <= LW'(10)) hdr_q[len_q[3:0]] <= rx_data;
			if (len_q >= LW'(2)) begin
				crc_hi_q <= rx_data;
				crc_lo_q <= crc_hi_q;
			end
		end
		rdat_q <= mem_q[rd_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rd_q <= '0;
			rdat_v_q <= 1'b0;
			crc_q <= mbpm_pkg::CrcInit;
			out_valid <= 1'b0;
			o_kind <= mbpm_pkg::KindTx;
			o_tx <= 8'h00;
			o_board <= 2'd0;
			o_rec <= '0;
			o_err <= mbpm_pkg::ErrOk;
			o_last <= 1'b0;
			for (int i = 0; i < NUM_BOARDS; i++) tbl_q[i] <= '0;
		end else begin
			if (cmd.buf_clear) len_q <= '0;
			else if (rx_wr && len_q < LW'(REPLY_BYTES)) len_q <= len_q + LW'(1);
			rdat_v_q <= 1'b0;
			if (cmd.rd_start) rd_q <= '0;
			else if (cmd.crc_byte && !cmd.crc_req && rd_q < len_m2 && !rdat_v_q) begin
				rd_q <= rd_q + LW'(1);
				rdat_v_q <= 1'b1;
			end
			if (cmd.crc_clear) crc_q <= mbpm_pkg::CrcInit;
			else if (cmd.crc_byte && cmd.crc_req) crc_q <= mbpm_pkg::crc_step(crc_q, req_byte);
			else if (rdat_v_q) crc_q <= mbpm_pkg::crc_step(crc_q, rdat_q);
			if (out_take) out_valid <= 1'b0;
			if (cmd.out_tx) begin
				out_valid <= 1'b1;
				o_kind <= mbpm_pkg::KindTx;
				o_tx <= req_byte;
				o_board <= 2'(cursor);
				o_rec <= '0;
				o_err <= mbpm_pkg::ErrOk;
				o_last <= cmd.out_last;
			end
			if (cmd.judge) begin : judge_blk
				mbpm_pkg::board_rec_t r;
				logic [2:0] e;
				logic [15:0] st, tg;
				logic [7:0] lim;
				r = tbl_q[cursor];
				lim = (fail_limit == 8'd0) ? 8'd1 : fail_limit;
				st = {hdr_q[3], hdr_q[4]};
				tg = {hdr_q[9], hdr_q[10]};
				if (len_q < LW'(mbpm_pkg::MinReply))
					e = (len_q >= LW'(4) && b1_q == mbpm_pkg::FuncExc) ? mbpm_pkg::ErrExc
						: mbpm_pkg::ErrNoRep;
				else if (b0_q != addr || b1_q != mbpm_pkg::FuncRead) e = mbpm_pkg::ErrHeader;
				else if ({crc_hi_q, crc_lo_q} != crc_q) e = mbpm_pkg::ErrCrc;
				else if (b2_q < 8'd8) e = mbpm_pkg::ErrCount;
				else e = mbpm_pkg::ErrOk;
				if (e == mbpm_pkg::ErrOk) begin
					r.state = (st <= 16'd3) ? st[1:0] : 2'd1;
					r.valve = (st == 16'd2);
					r.flow = {hdr_q[5], hdr_q[6]};
					r.dispensed = {hdr_q[7], hdr_q[8]};
					if (tg != 16'd0) r.target = tg;
					r.fails = 8'd0;
				end else begin
					if (r.fails != 8'hFF) r.fails = r.fails + 8'd1;
					if (r.fails >= lim) r.state = 2'd0;
				end
				tbl_q[cursor] <= r;
				out_valid <= 1'b1;
				o_kind <= mbpm_pkg::KindReport;
				o_tx <= 8'h00;
				o_board <= 2'(cursor);
				o_rec <= r;
				o_err <= e;
				o_last <= cmd.out_last;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/mbpm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpm_ctrl: poll sequencer
// Counts ticks, sequences requests, CRC walks and reports.
// ----------------------------------------------------------------------------
module mbpm_ctrl #(
	parameter int NUM_BOARDS = mbpm_pkg::NumBoards,
	localparam int BW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              in_func,
	output logic                   in_ready,
	output logic                   rx_wr,
	input  wire logic [15:0]       poll_period_ms,
	input  wire logic [15:0]       reply_timeout_ms,
	output mbpm_pkg::dp_cmd_t      cmd,
	input  wire mbpm_pkg::dp_stat_t stat,
	input  wire logic              out_valid,
	input  wire logic              out_take,
	output logic [BW-1:0]          cursor
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RCRC  = 6'b000010,
		S_QCRC  = 6'b000100,
		S_JUDGE = 6'b001000,
		S_REQ   = 6'b010000,
		S_WAIT  = 6'b100000
	} state_t;

	state_t state_q;
	logic busy_q;
	logic [15:0] per_q, wait_q;
	logic [3:0] idx_q;
	logic [BW-1:0] cur_q;
	logic out_free;
	logic last_board;

	assign cursor = cur_q;
	assign out_free = !out_valid || out_take;
	assign in_ready = (state_q == S_IDLE);
	assign rx_wr = in_fire && in_func && busy_q;
	assign last_board = (cur_q == BW'(NUM_BOARDS - 1));

	always_comb begin
		cmd = '0;
		cmd.req_idx = idx_q[2:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.crc_clear = 1'b1;
				cmd.rd_start = 1'b1;
			end
			S_RCRC: cmd.crc_byte = 1'b1;
			S_QCRC: begin
				cmd.crc_byte = 1'b1;
				cmd.crc_req = 1'b1;
				cmd.buf_clear = 1'b1;
			end
			S_JUDGE: begin
				cmd.judge = out_free;
				cmd.crc_clear = out_free;
				cmd.out_last = last_board;
			end
			S_REQ: begin
				cmd.out_tx = out_free;
				cmd.out_last = (idx_q == 4'd7);
			end
			S_WAIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			per_q <= '0;
			wait_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire && !in_func) begin
					if (per_q != 16'hFFFF) per_q <= per_q + 16'd1;
					if (!busy_q) begin
						if ((per_q != 16'hFFFF ? per_q + 16'd1 : per_q) >= poll_period_ms) begin
							per_q <= '0;
							cur_q <= '0;
							idx_q <= '0;
							state_q <= S_QCRC;
						end
					end else if (wait_q >= reply_timeout_ms) begin
						state_q <= S_WAIT;
					end else begin
						wait_q <= wait_q + 16'd1;
					end
				end
				S_WAIT: state_q <= stat.needs_crc ? S_RCRC : S_JUDGE;
				S_RCRC: if (stat.rd_done) state_q <= S_JUDGE;
				S_JUDGE: if (out_free) begin
					if (last_board) begin
						cur_q <= '0;
						busy_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + BW'(1);
						idx_q <= '0;
						state_q <= S_QCRC;
					end
				end
				S_QCRC: begin
					if (idx_q == 4'd5) begin
						idx_q <= 4'd0;
						state_q <= S_REQ;
					end else idx_q <= idx_q + 4'd1;
				end
				S_REQ: if (out_free) begin
					if (idx_q == 4'd7) begin
						busy_q <= 1'b1;
						wait_q <= '0;
						state_q <= S_IDLE;
					end else idx_q <= idx_q + 4'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/modbus_rtu_poll_master_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_poll_master_unit: Modbus RTU FC04 poll master
// Polls boards in turn, checks replies and reports board records.
// ----------------------------------------------------------------------------
// channel | dir | carries
// in_ch   | in  | tick (func 0) or received byte (func 1)
// out_ch  | out | request byte (kind 0) or board report (kind 1)
// cfg     | in  | we / idx / wdata register writes
// A tick that starts a request holds the input while it runs 6 CRC steps and
// sends 8 bytes. A timeout tick holds it through one select state, a CRC walk
// over length-2 bytes when the header is good (one buffer read and one fold per
// byte), and one report before the next request, if any.
// Output stalls hold the sequencer. Reset clears the board table and all counters at once.
// ----------------------------------------------------------------------------
module modbus_rtu_poll_master_unit #(
	parameter int NUM_BOARDS  = mbpm_pkg::NumBoards,
	parameter int REPLY_BYTES = mbpm_pkg::ReplyBytes
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mbpm_in_if.sink         in_ch,
	mbpm_out_if.source      out_ch,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [15:0] cfg_wdata
);
	localparam int BW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
	logic [15:0] period_q, timeout_q;
	logic [7:0] limit_q, addr_q;
	mbpm_pkg::dp_cmd_t cmd;
	mbpm_pkg::dp_stat_t stat;
	logic in_fire, out_take, rx_wr, out_valid, in_ready;
	logic [BW-1:0] cursor;
	mbpm_pkg::board_rec_t rec;

	assign in_ch.ready = in_ready;
	assign in_fire = in_ch.valid && in_ready;
	assign out_take = out_valid && out_ch.ready;
	assign out_ch.valid = out_valid;
	assign out_ch.board_state = rec.state;
	assign out_ch.valve_open = rec.valve;
	assign out_ch.flow_count = rec.flow;
	assign out_ch.dispensed_tenths = rec.dispensed;
	assign out_ch.target_tenths = rec.target;
	assign out_ch.fail_count = rec.fails;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= mbpm_pkg::PeriodReset;
			timeout_q <= mbpm_pkg::TimeoutReset;
			limit_q <= mbpm_pkg::LimitReset;
			addr_q <= mbpm_pkg::AddrReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mbpm_pkg::RegPeriod: period_q <= cfg_wdata;
				mbpm_pkg::RegTimeout: timeout_q <= cfg_wdata;
				mbpm_pkg::RegLimit: limit_q <= cfg_wdata[7:0];
				mbpm_pkg::RegAddr: addr_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	mbpm_ctrl #(.NUM_BOARDS(NUM_BOARDS)) u_ctrl (
		.clk, .arst_n, .in_fire, .in_func(in_ch.func), .in_ready, .rx_wr,
		.poll_period_ms(period_q), .reply_timeout_ms(timeout_q),
		.cmd, .stat, .out_valid, .out_take, .cursor
	);

	mbpm_datapath #(.NUM_BOARDS(NUM_BOARDS), .REPLY_BYTES(REPLY_BYTES)) u_dp (
		.clk, .arst_n, .cmd, .stat, .rx_wr, .rx_data(in_ch.rx_byte), .cursor,
		.first_address(addr_q), .fail_limit(limit_q), .out_take, .out_valid,
		.o_kind(out_ch.kind), .o_tx(out_ch.tx_byte), .o_board(out_ch.board_index),
		.o_rec(rec), .o_err(out_ch.error_code), .o_last(out_ch.last)
	);
endmodule
`default_nettype wire

/* rtl/core/mbpm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbpm_checker: port-level checks
// Watches the channel ports of the poll master.
// ----------------------------------------------------------------------------
module mbpm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_kind,
	input wire logic [7:0] out_tx,
	input wire logic [2:0] out_err
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == 1'b0 |-> out_err == 3'd0) else $error("error on tx");
	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == 1'b1 |-> out_tx == 8'd0) else $error("tx on report");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_tx) && $stable(out_err))
		else $error("result changed while stalled");
endmodule

bind modbus_rtu_poll_master_unit mbpm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_kind(out_ch.kind), .out_tx(out_ch.tx_byte), .out_err(out_ch.error_code)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Modbus RTU poll master check
// Drives ticks and reply bytes, predicts request frames and board reports
// from an own model of the poll cycle, and compares every output transaction.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} poll_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic [1:0]  board_index;
		logic [1:0]  board_state;
		logic        valve_open;
		logic [15:0] flow_count;
		logic [15:0] dispensed_tenths;
		logic [15:0] target_tenths;
		logic [7:0]  fail_count;
		logic [2:0]  error_code;
		logic        last;
	} poll_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_wdata;

	mbpm_in_if in_ch ();
	mbpm_out_if out_ch ();

	modbus_rtu_poll_master_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// model state
	logic [15:0] m_period, m_timeout;
	logic [7:0]  m_limit, m_addr;
	logic        m_busy;
	int          m_cursor;
	logic [15:0] m_per_cnt, m_wait_cnt;
	logic [7:0]  m_reply [mbpm_pkg::ReplyBytes];
	int          m_len;
	mbpm_pkg::board_rec_t m_boards [mbpm_pkg::NumBoards];

	poll_in_t  pending_items [$];
	poll_out_t expected_results [$];
	int sender_idle, receiver_idle;
	int mismatches, errors;

	function automatic logic [15:0] frame_crc(input logic [7:0] b [mbpm_pkg::ReplyBytes],
		input int n);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < n; i++) begin
			c = c ^ {8'h00, b[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] board_address(input int cur);
		return m_addr + 8'(cur);
	endfunction

	task automatic push_result(input logic kind, input logic [7:0] tx, input logic rep);
		poll_out_t r;
		r = '0;
		r.kind = kind;
		r.tx_byte = tx;
		r.board_index = 2'(m_cursor);
		if (rep) begin
			r.board_state = m_boards[m_cursor].state;
			r.valve_open = m_boards[m_cursor].valve;
			r.flow_count = m_boards[m_cursor].flow;
			r.dispensed_tenths = m_boards[m_cursor].dispensed;
			r.target_tenths = m_boards[m_cursor].target;
			r.fail_count = m_boards[m_cursor].fails;
		end
		expected_results.push_back(r);
	endtask

	task automatic issue_request();
		logic [7:0] q [mbpm_pkg::ReplyBytes];
		logic [15:0] c;
		q[0] = board_address(m_cursor);
		q[1] = mbpm_pkg::FuncRead; q[2] = 0; q[3] = 0; q[4] = 0; q[5] = 8'h04;
		c = frame_crc(q, 6);
		q[6] = c[7:0];
		q[7] = c[15:8];
		for (int i = 0; i < 8; i++)
			push_result(mbpm_pkg::KindTx, q[i], 1'b0);
		m_busy = 1;
		m_wait_cnt = 0;
		m_len = 0;
	endtask

	function automatic logic [2:0] judge_reply();
		logic [7:0] lim;
		logic [2:0] e;
		logic [15:0] st, tg;
		lim = (m_limit == 0) ? 8'd1 : m_limit;
		if (m_len < mbpm_pkg::MinReply)
			e = (m_len >= 4 && m_reply[1] == mbpm_pkg::FuncExc) ? mbpm_pkg::ErrExc
				: mbpm_pkg::ErrNoRep;
		else if (m_reply[0] != board_address(m_cursor) || m_reply[1] != mbpm_pkg::FuncRead)
			e = mbpm_pkg::ErrHeader;
		else if ({m_reply[m_len-1], m_reply[m_len-2]} != frame_crc(m_reply, m_len - 2))
			e = mbpm_pkg::ErrCrc;
		else if (m_reply[2] < 8)
			e = mbpm_pkg::ErrCount;
		else
			e = mbpm_pkg::ErrOk;
		if (e != mbpm_pkg::ErrOk) begin
			if (m_boards[m_cursor].fails != 8'hFF)
				m_boards[m_cursor].fails++;
			if (m_boards[m_cursor].fails >= lim)
				m_boards[m_cursor].state = 0;
		end else begin
			st = {m_reply[3], m_reply[4]};
			tg = {m_reply[9], m_reply[10]};
			m_boards[m_cursor].state = (st <= 3) ? st[1:0] : 2'd1;
			m_boards[m_cursor].valve = (st == 2);
			m_boards[m_cursor].flow = {m_reply[5], m_reply[6]};
			m_boards[m_cursor].dispensed = {m_reply[7], m_reply[8]};
			if (tg != 0)
				m_boards[m_cursor].target = tg;
			m_boards[m_cursor].fails = 0;
		end
		return e;
	endfunction

	task automatic predict_item(input poll_in_t it);
		int n0;
		logic [2:0] e;
		n0 = expected_results.size();
		if (it.func) begin
			if (m_busy && m_len < mbpm_pkg::ReplyBytes) begin
				m_reply[m_len] = it.rx_byte;
				m_len++;
			end
			return;
		end
		if (m_per_cnt != 16'hFFFF)
			m_per_cnt++;
		if (!m_busy) begin
			if (m_per_cnt >= m_period) begin
				m_per_cnt = 0;
				m_cursor = 0;
				issue_request();
			end
		end else if (m_wait_cnt >= m_timeout) begin
			e = judge_reply();
			push_result(mbpm_pkg::KindReport, 8'h00, 1'b1);
			expected_results[$].error_code = e;
			m_cursor++;
			if (m_cursor < mbpm_pkg::NumBoards) begin
				issue_request();
			end else begin
				m_cursor = 0;
				m_busy = 0;
			end
		end else begin
			m_wait_cnt++;
		end
		if (expected_results.size() > n0)
			expected_results[$].last = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.func <= 0;
			in_ch.rx_byte <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid)
				predict_item({in_ch.func, in_ch.rx_byte});
			if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle) begin
				in_ch.valid <= 1;
				{in_ch.func, in_ch.rx_byte} <= pending_items.pop_front();
			end else begin
				in_ch.valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		poll_out_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.tx_byte, out_ch.board_index, out_ch.board_state,
					out_ch.valve_open, out_ch.flow_count, out_ch.dispensed_tenths,
					out_ch.target_tenths, out_ch.fail_count, out_ch.error_code, out_ch.last};
				if (expected_results.size() == 0) begin
					errors++;
					if (mismatches < 10)
						$display("unexpected result %h", got);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (mismatches < 10)
							$display("mismatch: expected %h actual %h", want, got);
						mismatches++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		case (idx)
			mbpm_pkg::RegPeriod: m_period = v;
			mbpm_pkg::RegTimeout: m_timeout = v;
			mbpm_pkg::RegLimit: m_limit = v[7:0];
			default: m_addr = v[7:0];
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_ticks(input int n);
		repeat (n) pending_items.push_back('{1'b0, 8'h00});
	endtask

	task automatic add_byte(input logic [7:0] b);
		pending_items.push_back('{1'b1, b});
	endtask

	// reply for board at address a: kind 0 good, 1 exception, 2 bad header,
	// 3 bad crc, 4 short count, 5 short frame, 6 overlong / noise
	task automatic add_reply(input logic [7:0] a, input int kind);
		logic [7:0] f [mbpm_pkg::ReplyBytes];
		logic [15:0] c;
		int n;
		n = 13;
		f[0] = a; f[1] = mbpm_pkg::FuncRead; f[2] = 8;
		for (int i = 3; i < 11; i++)
			f[i] = $urandom_range(255);
		if ($urandom_range(1)) begin
			f[3] = 0;
			f[4] = $urandom_range(5);
		end
		if ($urandom_range(3) == 0) begin
			f[9] = 0;
			f[10] = 0;
		end
		if (kind == 2) begin
			if ($urandom_range(1)) f[0] = a + 8'(1 + $urandom_range(254));
			else f[1] = 8'(~8'h04);
		end
		if (kind == 4)
			f[2] = $urandom_range(7);
		c = frame_crc(f, 11);
		f[11] = c[7:0];
		f[12] = c[15:8];
		if (kind == 3)
			f[11 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
		if (kind == 1) begin
			f[1] = mbpm_pkg::FuncExc;
			n = 4 + $urandom_range(8);
		end
		if (kind == 5)
			n = $urandom_range(12);
		if (kind == 6)
			n = 14 + $urandom_range(24);
		for (int i = 0; i < n; i++)
			add_byte(i < 13 ? f[i] : 8'($urandom_range(255)));
	endtask

	// one full poll cycle with random reply outcomes
	task automatic add_cycle(input int period, input int tmo, input logic [7:0] a0);
		int k;
		add_ticks(period);
		for (int b = 0; b < mbpm_pkg::NumBoards; b++) begin
			k = $urandom_range(9);
			if (k < 4) add_reply(a0 + 8'(b), 0);
			else if (k < 9) add_reply(a0 + 8'(b), k - 3);
			else if ($urandom_range(1)) add_reply(a0 + 8'(b), 6);
			add_ticks(tmo + 1);
		end
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int per, tmo;
		logic [7:0] a0;
		errors = 0;
		mismatches = 0;
		sender_idle = 27;
		receiver_idle = 68;
		cfg_we = 0;
		cfg_idx = 0;
		cfg_wdata = 0;
		m_period = mbpm_pkg::PeriodReset;
		m_timeout = mbpm_pkg::TimeoutReset;
		m_limit = mbpm_pkg::LimitReset;
		m_addr = mbpm_pkg::AddrReset;
		m_busy = 0;
		m_cursor = 0;
		m_per_cnt = 0;
		m_wait_cnt = 0;
		m_len = 0;
		for (int i = 0; i < mbpm_pkg::ReplyBytes; i++) m_reply[i] = 0;
		for (int i = 0; i < mbpm_pkg::NumBoards; i++) m_boards[i] = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: minimal timings, idle bytes, good, exception, bad header and bad crc replies
		write_reg(mbpm_pkg::RegPeriod, 16'd0);
		write_reg(mbpm_pkg::RegTimeout, 16'd0);
		write_reg(mbpm_pkg::RegLimit, 16'd0);
		write_reg(mbpm_pkg::RegAddr, 16'd255);
		add_byte(8'hFF);
		add_byte(8'h00);
		add_ticks(1);
		add_reply(8'd255, 0);
		add_ticks(1);
		add_reply(8'd0, 1);
		add_ticks(1);
		add_reply(8'd1, 2);
		add_ticks(1);
		add_reply(8'd2, 3);
		add_ticks(1);
		wait_drained();
		write_reg(mbpm_pkg::RegPeriod, 16'd2);
		write_reg(mbpm_pkg::RegTimeout, 16'd1);
		write_reg(mbpm_pkg::RegLimit, 16'd255);
		write_reg(mbpm_pkg::RegAddr, 16'd1);
		add_cycle(2, 1, 8'd1);
		wait_drained();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				sender_idle = 68;
				receiver_idle = 27;
			end else if (ph == 4) begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			per = $urandom_range(1, 4);
			tmo = $urandom_range(0, 3);
			a0 = (ph == 3) ? 8'd247 : 8'($urandom_range(1, 247));
			write_reg(mbpm_pkg::RegPeriod, 16'(per));
			write_reg(mbpm_pkg::RegTimeout, 16'(tmo));
			write_reg(mbpm_pkg::RegLimit, 16'((ph == 5) ? 255 : $urandom_range(1, 4)));
			write_reg(mbpm_pkg::RegAddr, {8'h00, a0});
			add_cycle(per, tmo, a0);
			for (int i = 0; i < 6; i++)
				pending_items.push_back('{1'($urandom_range(1)),
					8'($urandom_range(255))});
			wait_drained();
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/mbpm_pkg.sv
rtl/core/mbpm_if.sv
rtl/core/mbpm_datapath.sv
rtl/core/mbpm_ctrl.sv
rtl/core/modbus_rtu_poll_master_unit.sv
rtl/core/mbpm_checker.sv
tb/testbench.sv
